// ----- src/ktst_pkg.sv -----
package ktst_pkg;

  // input kinds
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_CANCEL = 2'd2;
  localparam logic [1:0] KIND_QUERY  = 2'd3;

  // result status codes
  localparam logic [2:0] STAT_STARTED   = 3'd0;
  localparam logic [2:0] STAT_FULL      = 3'd1;
  localparam logic [2:0] STAT_CANCELLED = 3'd2;
  localparam logic [2:0] STAT_QUERY     = 3'd3;
  localparam logic [2:0] STAT_EXPIRED   = 3'd4;

  // input item
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  timer_id;
    logic [31:0] duration;
    logic [31:0] argument;
  } item_t;

  // result item
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  timer_id_out;
    logic [31:0] argument_out;
    logic        running;
    logic        last;
  } result_t;

  // command token handed from cell to cell
  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [7:0]  id;
    logic [31:0] dur;
    logic [31:0] arg;
    logic [31:0] now;
    logic        found;
  } tok_t;

  // expiry seen by one cell
  typedef struct packed {
    logic        valid;
    logic [7:0]  id;
    logic [31:0] arg;
  } evt_t;

endpackage

// ----- src/keyed_timer_slot_table.sv -----
// Keyed timer slot table: SLOTS timer slots, one per cell of a chain.
// Input channel: item_i is taken at a rising edge with start high and busy
// low. An item is a tick, a timer start, a cancel or a query.
// Output channel: each result sits on result_o for one cycle while
// result_valid_o is high; the receiver takes it at the end of that cycle and
// cannot stall it.
// An accepted item travels down the chain one cell per cycle; each cell acts
// on its own slot as the item passes. Start, cancel and query give one result
// on the ports once the item has left the last cell and passed the done and
// result registers. A tick gives its expiries in slot order while it travels
// (each held back in a pending register so the final one can carry last) and
// may give none. busy stays high from acceptance until the cycle the closing
// result is shown, so a new item is taken only once the last one has left the
// chain; the chain length sets how long that takes.
// Reset clears the time to zero and frees every slot.
module keyed_timer_slot_table import ktst_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output logic    result_valid_o,
  output result_t result_o
);

  logic        accept;
  logic        busy_q, busy_d;
  logic [31:0] now_q, now_d;
  tok_t        tok_in;
  tok_t        tok [SLOTS+1];
  evt_t        evt [SLOTS];
  evt_t        evt_any;
  logic        done_q;
  tok_t        fin_q;
  evt_t        pend_q, pend_d;
  logic        res_valid_q, res_valid_d;
  result_t     res_q, res_d;

  assign accept = start && !busy_q;

  // time and command token entering the chain
  always_comb begin
    now_d = now_q;
    if (accept && (item_i.kind == KIND_TICK)) begin
      now_d = now_q + 32'd1;
    end
    tok_in.valid = accept;
    tok_in.kind  = item_i.kind;
    tok_in.id    = item_i.timer_id;
    tok_in.dur   = item_i.duration;
    tok_in.arg   = item_i.argument;
    tok_in.now   = (item_i.kind == KIND_TICK) ? (now_q + 32'd1) : now_q;
    tok_in.found = 1'b0;
  end

  assign tok[0] = tok_in;

  // chain of slot cells
  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    ktst_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (tok[k]),
      .tok_o (tok[k+1]),
      .evt_o (evt[k])
    );
  end

  // at most one cell reports an expiry per cycle
  always_comb begin
    evt_any = '0;
    for (int k = 0; k < SLOTS; k++) begin
      if (evt[k].valid) begin
        evt_any = evt_t'(evt_any | evt[k]);
      end
    end
  end

  // result sequencing: hold each expiry back in pend_q to mark the last one
  always_comb begin
    pend_d      = pend_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    busy_d      = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end
    if (evt_any.valid) begin
      if (pend_q.valid) begin
        res_valid_d        = 1'b1;
        res_d.status       = STAT_EXPIRED;
        res_d.timer_id_out = pend_q.id;
        res_d.argument_out = pend_q.arg;
      end
      pend_d = evt_any;
    end else if (done_q) begin
      busy_d       = 1'b0;
      pend_d.valid = 1'b0;
      unique case (fin_q.kind)
        KIND_TICK: begin
          res_valid_d        = pend_q.valid;
          res_d.status       = STAT_EXPIRED;
          res_d.timer_id_out = pend_q.id;
          res_d.argument_out = pend_q.arg;
          res_d.last         = 1'b1;
        end
        KIND_START: begin
          res_valid_d        = 1'b1;
          res_d.status       = fin_q.found ? STAT_STARTED : STAT_FULL;
          res_d.timer_id_out = fin_q.id;
          res_d.last         = 1'b1;
        end
        KIND_CANCEL: begin
          res_valid_d        = 1'b1;
          res_d.status       = STAT_CANCELLED;
          res_d.timer_id_out = fin_q.id;
          res_d.last         = 1'b1;
        end
        default: begin
          res_valid_d        = 1'b1;
          res_d.status       = STAT_QUERY;
          res_d.timer_id_out = fin_q.id;
          res_d.running      = fin_q.found;
          res_d.last         = 1'b1;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      now_q       <= '0;
      done_q      <= 1'b0;
      pend_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      now_q       <= now_d;
      done_q      <= tok[SLOTS].valid;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    fin_q <= tok[SLOTS];
    res_q <= res_d;
  end

  assign busy           = busy_q;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // the closing step never meets a cell expiry
  a_done_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !evt_any.valid)
    else $error("chain end coincides with an expiry");

  // a result is only formed while an item is in flight
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(busy_q))
    else $error("result without item in flight");

  // an accepted item holds busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("busy not raised on accept");

  // the closing step releases busy
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !busy_q)
    else $error("busy not released at chain end");

  // no expiry is held once the item is finished
  a_pend_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> !pend_q.valid)
    else $error("expiry left pending while idle");

endmodule

// ----- src/ktst_cell.sv -----
module ktst_cell import ktst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  tok_t tok_i,
  output tok_t tok_o,
  output evt_t evt_o
);

  logic        valid_q, valid_d;
  logic [7:0]  ident_q;
  logic [31:0] start_q;
  logic [31:0] dur_q;
  logic [31:0] arg_q;
  tok_t        tok_q, tok_d;
  evt_t        evt_q, evt_d;

  logic        id_hit;
  logic [31:0] elapsed;
  logic        take, drop_dup, cancel, fire;

  // slot decisions for the token passing this cell
  always_comb begin
    id_hit   = valid_q && (ident_q == tok_i.id);
    elapsed  = tok_i.now - start_q;
    take     = tok_i.valid && (tok_i.kind == KIND_START) && !tok_i.found &&
               (!valid_q || (ident_q == tok_i.id));
    drop_dup = tok_i.valid && (tok_i.kind == KIND_START) && tok_i.found && id_hit;
    cancel   = tok_i.valid && (tok_i.kind == KIND_CANCEL) && !tok_i.found && id_hit;
    fire     = tok_i.valid && (tok_i.kind == KIND_TICK) && valid_q && (elapsed >= dur_q);
  end

  // next slot state, token and expiry
  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (drop_dup || cancel || fire) begin
      valid_d = 1'b0;
    end
    tok_d       = tok_i;
    tok_d.found = tok_i.found | take |
                  (((tok_i.kind == KIND_CANCEL) || (tok_i.kind == KIND_QUERY)) && id_hit);
    evt_d.valid = fire;
    evt_d.id    = ident_q;
    evt_d.arg   = arg_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
      evt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
      evt_q   <= evt_d;
    end
  end

  // slot payload, written when the slot is taken
  always_ff @(posedge clk_i) begin
    if (take) begin
      ident_q <= tok_i.id;
      start_q <= tok_i.now;
      dur_q   <= tok_i.dur;
      arg_q   <= tok_i.arg;
    end
  end

  assign tok_o = tok_q;
  assign evt_o = evt_q;

endmodule

// ----- dv/ktst_checker.sv -----
`timescale 1ns / 100ps

module ktst_checker import ktst_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  logic    busy_i,
  input  item_t   item_i,
  input  logic    result_valid_i,
  input  result_t result_i,
  output int      error_count_o,
  output int      pending_o
);

  // predicted timer table
  logic [31:0] now_ticks;
  logic        slot_live  [SLOTS];
  logic [7:0]  slot_key   [SLOTS];
  logic [31:0] slot_since [SLOTS];
  logic [31:0] slot_span  [SLOTS];
  logic [31:0] slot_word  [SLOTS];

  // results still owed by the block, oldest first
  result_t due_results [$];

  task automatic report_mismatch(string what);
    // keep the log short if the block is badly broken
    if (error_count_o < 40) $display("ktst_checker: %0t ns: %s", $realtime, what);
    error_count_o++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  function automatic result_t make_result(logic [2:0] status, logic [7:0] id,
                                          logic [31:0] arg, logic run);
    result_t r;
    r.status       = status;
    r.timer_id_out = id;
    r.argument_out = arg;
    r.running      = run;
    r.last         = 1'b1;
    return r;
  endfunction

  function automatic int find_key(logic [7:0] id);
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_live[i] && slot_key[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic logic slot_due(int i);
    logic [31:0] elapsed;
    elapsed = now_ticks - slot_since[i];
    return slot_live[i] && (elapsed >= slot_span[i]);
  endfunction

  // advance the table by one item and queue the results it causes
  task automatic table_update(item_t it);
    int      hit;
    int      last_due;
    result_t r;
    hit      = -1;
    last_due = -1;
    case (it.kind)
      KIND_TICK: begin
        now_ticks = now_ticks + 32'd1;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_due(i)) last_due = i;
        end
        // expiries in slot order, last flag on the final one
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_due(i)) begin
            r = make_result(STAT_EXPIRED, slot_key[i], slot_word[i], 1'b0);
            r.last = (i == last_due);
            due_results.push_back(r);
            slot_live[i] = 1'b0;
          end
        end
      end
      KIND_START: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (hit < 0 && (!slot_live[i] || slot_key[i] == it.timer_id)) hit = i;
        end
        if (hit < 0) begin
          due_results.push_back(make_result(STAT_FULL, it.timer_id, '0, 1'b0));
        end else begin
          slot_live[hit]  = 1'b1;
          slot_key[hit]   = it.timer_id;
          slot_since[hit] = now_ticks;
          slot_span[hit]  = it.duration;
          slot_word[hit]  = it.argument;
          // drop later copies of the same identity
          for (int j = hit + 1; j < SLOTS; j++) begin
            if (slot_live[j] && slot_key[j] == it.timer_id) slot_live[j] = 1'b0;
          end
          due_results.push_back(make_result(STAT_STARTED, it.timer_id, '0, 1'b0));
        end
      end
      KIND_CANCEL: begin
        hit = find_key(it.timer_id);
        if (hit >= 0) slot_live[hit] = 1'b0;
        due_results.push_back(make_result(STAT_CANCELLED, it.timer_id, '0, 1'b0));
      end
      default: begin
        hit = find_key(it.timer_id);
        due_results.push_back(make_result(STAT_QUERY, it.timer_id, '0, hit >= 0));
      end
    endcase
  endtask

  // compare results and follow accepted items
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      now_ticks = '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_live[i]  = 1'b0;
        slot_key[i]   = '0;
        slot_since[i] = '0;
        slot_span[i]  = '0;
        slot_word[i]  = '0;
      end
      due_results.delete();
      pending_o = 0;
    end else begin
      if (result_valid_i) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing expected", result_i));
        end else begin
          want = due_results.pop_front();
          check_field("status", 32'(result_i.status), 32'(want.status));
          check_field("timer_id_out", 32'(result_i.timer_id_out), 32'(want.timer_id_out));
          check_field("argument_out", result_i.argument_out, want.argument_out);
          check_field("running", 32'(result_i.running), 32'(want.running));
          check_field("last", 32'(result_i.last), 32'(want.last));
        end
      end
      if (start_i && !busy_i) table_update(item_i);
      pending_o = due_results.size();
    end
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import ktst_pkg::*;

  localparam int SLOTS        = 16;
  localparam int RANDOM_ITEMS = 300;
  localparam int IDLE_LIMIT   = 4000;

  logic    clk_i  = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start  = 1'b0;
  logic    busy;
  item_t   item_d = '0;
  logic    result_valid;
  result_t result;
  int      error_count;
  int      pending_count;
  int      idle_cycles = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  keyed_timer_slot_table #(.SLOTS(SLOTS)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_d),
    .result_valid_o(result_valid),
    .result_o      (result)
  );

  ktst_checker #(.SLOTS(SLOTS)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .item_i        (item_d),
    .result_valid_i(result_valid),
    .result_i      (result),
    .error_count_o (error_count),
    .pending_o     (pending_count)
  );

  // watchdog on cycles with no item and no result
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic item_t make_item(logic [1:0] kind, logic [7:0] id,
                                      logic [31:0] dur, logic [31:0] arg);
    item_t it;
    it.kind     = kind;
    it.timer_id = id;
    it.duration = dur;
    it.argument = arg;
    return it;
  endfunction

  // mostly a small set of identities so starts, cancels and expiries collide
  function automatic item_t random_item();
    item_t       it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) it.kind = KIND_TICK;
    else if (pick < 70) it.kind = KIND_START;
    else if (pick < 85) it.kind = KIND_CANCEL;
    else it.kind = KIND_QUERY;
    if ($urandom_range(0, 9) < 7) it.timer_id = 8'($urandom_range(0, 7));
    else it.timer_id = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 62) it.duration = $urandom_range(0, 8);
    else if (pick < 92) it.duration = $urandom_range(0, 40);
    else begin
      // long timers only on reusable identities so the table keeps turning over
      it.duration = $urandom;
      it.timer_id = 8'($urandom_range(0, 7));
    end
    it.argument = $urandom;
    return it;
  endfunction

  // present an item from a falling edge until it is taken; start is left high
  task automatic send(item_t it);
    start  <= 1'b1;
    item_d <= it;
    while (busy !== 1'b0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    int    sent;
    int    burst;
    int    gap;
    logic  paused;
    sent   = 0;
    paused = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty table, zero duration, restart, full table
    send(make_item(KIND_QUERY, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send(make_item(KIND_CANCEL, 8'hFF, 32'h0, 32'h0));
    send(make_item(KIND_TICK, 8'h00, 32'h0, 32'h0));
    send(make_item(KIND_START, 8'h00, 32'h0, 32'hFFFF_FFFF));
    send(make_item(KIND_TICK, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send(make_item(KIND_START, 8'hFF, 32'hFFFF_FFFF, 32'h0));
    send(make_item(KIND_START, 8'h55, 32'd5, 32'hA5A5_A5A5));
    send(make_item(KIND_START, 8'h55, 32'd1, 32'h5A5A_5A5A));
    send(make_item(KIND_QUERY, 8'h55, 32'h0, 32'h0));
    for (int k = 0; k < SLOTS - 2; k++) begin
      send(make_item(KIND_START, 8'(8'h10 + k), 32'd2, $urandom));
    end
    send(make_item(KIND_START, 8'hAA, 32'd3, 32'h1234_5678));
    send(make_item(KIND_CANCEL, 8'hFF, 32'h0, 32'h0));

    // random bursts with random gaps
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++) begin
        send(random_item());
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        // let the block drain completely once
        start <= 1'b0;
        @(negedge clk_i);
        while (pending_count != 0) @(negedge clk_i);
        paused = 1'b1;
      end else if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end

    // drain and settle
    start <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    repeat (SLOTS + 4) @(negedge clk_i);
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/ktst_pkg.sv
src/ktst_cell.sv
src/keyed_timer_slot_table.sv
dv/ktst_checker.sv
dv/tb.sv
